// ===== rtl/ir_breathing_pwm_and_triangle_tone_tick_defines.svh =====
// ----------------------------------------------------------------------------
// Breathing PWM and triangle tone tick: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IR_BREATHING_PWM_AND_TRIANGLE_TONE_TICK_DEFINES_SVH
`define IR_BREATHING_PWM_AND_TRIANGLE_TONE_TICK_DEFINES_SVH

// condition holds at every edge out of reset
`define IBPT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the same edge
`define IBPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define IBPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ibpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Breathing PWM and triangle tone tick: package
// Shared constants, codes and state types for the tick block.
// ----------------------------------------------------------------------------
`default_nettype none

package ibpt_pkg;

  // counter limits
  localparam logic [4:0] RAMP_TOP      = 5'd15;
  localparam logic [6:0] PWM_FRAME_TOP = 7'd42;
  localparam logic [6:0] MS_PRESCALE   = 7'd75;
  localparam logic [7:0] TONE_RESET    = 8'd128;

  // request kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // configuration register indexes
  localparam logic [0:0] CFG_CODE_MODE    = 1'd0;
  localparam logic [0:0] CFG_TONE_DIVIDER = 1'd1;

  // one input request
  typedef struct packed {
    logic        kind;
    logic [5:0]  pulse_width;
    logic        carrier_gate;
    logic [15:0] countdown_value;
  } item_t;

  // configuration seen by the step logic
  typedef struct packed {
    logic       code_mode;
    logic [7:0] tone_divider;
  } cfg_t;

  // timer state; frame_period needs 7 bits since a wide pulse runs it to 64
  typedef struct packed {
    logic [4:0]  ramp_step;
    logic        ramp_rising;
    logic        burst_enabled;
    logic [6:0]  frame_period;
    logic        led_level;
    logic [7:0]  tone_ticks;
    logic [8:0]  tone_phase;
    logic [7:0]  tone_sample;
    logic [6:0]  ms_prescale;
    logic [31:0] ms_total;
    logic [15:0] countdown;
  } state_t;

  // timer state after reset
  localparam state_t STATE_RESET = '{
    ramp_step:     5'd0,
    ramp_rising:   1'b1,
    burst_enabled: 1'b1,
    frame_period:  7'd0,
    led_level:     1'b0,
    tone_ticks:    8'd0,
    tone_phase:    9'd0,
    tone_sample:   TONE_RESET,
    ms_prescale:   7'd0,
    ms_total:      32'd0,
    countdown:     16'd0
  };

endpackage

`default_nettype wire

// ===== rtl/ibpt_chan_if.sv =====
// ----------------------------------------------------------------------------
// Breathing PWM and triangle tone tick: channel interfaces
// Valid/ready channels for the input requests and the result requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface ibpt_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [5:0]  pulse_width;
  logic        carrier_gate;
  logic [15:0] countdown_value;

  modport source (output valid, kind, pulse_width, carrier_gate, countdown_value,
                  input ready);
  modport sink   (input valid, kind, pulse_width, carrier_gate, countdown_value,
                  output ready);
endinterface

interface ibpt_out_if;
  logic        valid;
  logic        ready;
  logic        ir_led;
  logic [7:0]  tone_level;
  logic [31:0] ms_count;
  logic        countdown_done;

  modport source (output valid, ir_led, tone_level, ms_count, countdown_done,
                  input ready);
  modport sink   (input valid, ir_led, tone_level, ms_count, countdown_done,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/ibpt_step.sv =====
// ----------------------------------------------------------------------------
// Breathing PWM and triangle tone tick: next-state logic
// Computes the timer state after one request from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module ibpt_step
  import ibpt_pkg::*;
(
  input  wire state_t cur,
  input  wire cfg_t   cfg,
  input  wire item_t  item,
  output state_t      nxt
);

  logic [4:0] step_dn;
  logic [6:0] frame_n;
  logic [7:0] ticks_inc;
  logic [8:0] phase_n;

  always_comb begin
    nxt       = cur;
    frame_n   = cur.frame_period;
    step_dn   = (cur.ramp_step != 5'd0) ? cur.ramp_step - 5'd1 : 5'd0;
    ticks_inc = cur.tone_ticks + 8'd1;
    phase_n   = cur.tone_phase + 9'd1;

    if (item.kind == KIND_LOAD) begin
      // load: countdown takes the value, gate off clears the led
      nxt.countdown = item.countdown_value;
      if (!item.carrier_gate) begin
        nxt.led_level = 1'b0;
      end
    end else begin
      if (cfg.code_mode) begin
        // gated carrier and countdown
        if (item.carrier_gate) begin
          nxt.led_level = ~cur.led_level;
        end
        if (cur.countdown != 16'd0) begin
          nxt.countdown = cur.countdown - 16'd1;
        end
      end else begin
        // breathing ramp
        if (cur.ramp_rising) begin
          nxt.ramp_step = cur.ramp_step + 5'd1;
          if (cur.ramp_step >= RAMP_TOP) begin
            nxt.ramp_rising = 1'b0;
          end
          nxt.led_level = cur.burst_enabled ? ~cur.led_level : 1'b0;
        end else begin
          nxt.ramp_step = step_dn;
          if (step_dn == 5'd0) begin
            nxt.ramp_rising = 1'b1;
            frame_n         = cur.frame_period + 7'd1;
          end
          nxt.led_level = 1'b0;
        end

        // pwm frame
        nxt.frame_period = frame_n;
        if (frame_n > {1'b0, item.pulse_width}) begin
          nxt.burst_enabled = 1'b0;
          if (frame_n > PWM_FRAME_TOP) begin
            nxt.frame_period = 7'd0;
            if (item.pulse_width != 6'd0) begin
              nxt.burst_enabled = 1'b1;
            end
          end
        end

        // tone divider and triangle
        if (ticks_inc > cfg.tone_divider) begin
          nxt.tone_ticks  = 8'd0;
          nxt.tone_phase  = phase_n;
          nxt.tone_sample = phase_n[8] ? (8'd0 - phase_n[7:0]) : phase_n[7:0];
        end else begin
          nxt.tone_ticks = ticks_inc;
        end
      end

      // millisecond prescaler
      if (cur.ms_prescale >= MS_PRESCALE - 7'd1) begin
        nxt.ms_prescale = 7'd0;
        nxt.ms_total    = cur.ms_total + 32'd1;
      end else begin
        nxt.ms_prescale = cur.ms_prescale + 7'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ir_breathing_pwm_and_triangle_tone_tick.sv =====
// ----------------------------------------------------------------------------
// Breathing PWM and triangle tone tick: top level
// Timer tick block driving an IR carrier, a triangle tone and a ms count.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one request per tick (kind 0) or a countdown load
//   (kind 1); out_chan returns exactly one result per request: led level,
//   tone level, millisecond count and countdown-done flag, all as they
//   stand after that request.
//   cfg_we/cfg_index/cfg_data write code_mode (index 0) and tone_divider
//   (index 1); write them only while no request is in flight.
//   A request accepted at one edge has its result valid after that edge.
//   Throughput is one request per cycle while the receiver takes each result;
//   the state update and result sit in a single register stage behind the step logic.
//   When the receiver stalls, the result register holds and in_chan.ready
//   drops until the result is taken; no request is lost.
//   Synchronous reset clears all timer state to its start values (tone
//   level 128, ramp rising, burst enabled) and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_breathing_pwm_and_triangle_tone_tick_defines.svh"

module ir_breathing_pwm_and_triangle_tone_tick
  import ibpt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  ibpt_in_if.sink         in_chan,
  ibpt_out_if.source      out_chan,
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  cfg_t   cfg_r;
  state_t state_r;
  state_t state_nxt;
  item_t  item;
  logic   out_valid_r;
  logic   accept;

  // handshake: take a request whenever the result slot is free or leaving
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign item.kind            = in_chan.kind;
  assign item.pulse_width     = in_chan.pulse_width;
  assign item.carrier_gate    = in_chan.carrier_gate;
  assign item.countdown_value = in_chan.countdown_value;

  // next state for the request on the input
  ibpt_step u_step (
    .cur  (state_r),
    .cfg  (cfg_r),
    .item (item),
    .nxt  (state_nxt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODE_MODE:    cfg_r.code_mode    <= cfg_data[0];
        CFG_TONE_DIVIDER: cfg_r.tone_divider <= cfg_data;
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  // timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      out_valid_r <= in_chan.valid;
    end
  end

  // results come straight from the registered state
  assign out_chan.valid          = out_valid_r;
  assign out_chan.ir_led         = state_r.led_level;
  assign out_chan.tone_level     = state_r.tone_sample;
  assign out_chan.ms_count       = state_r.ms_total;
  assign out_chan.countdown_done = (state_r.countdown == 16'd0);

  // checks
  `IBPT_ASSERT_SAME(a_stall_blocks_input, out_chan.valid && !out_chan.ready, !in_chan.ready, "input taken while result stalled")
  `IBPT_ASSERT_ALWAYS(a_prescale_range, state_r.ms_prescale < MS_PRESCALE, "ms prescaler out of range")
  `IBPT_ASSERT_ALWAYS(a_ramp_range, state_r.ramp_step <= RAMP_TOP + 5'd1, "ramp step out of range")
  `IBPT_ASSERT_NEXT(a_load_done, accept && in_chan.kind == KIND_LOAD, out_chan.countdown_done == ($past(in_chan.countdown_value) == 16'd0), "countdown load not reflected")
  `IBPT_ASSERT_NEXT(a_ms_step, 1'b1, (state_r.ms_total == $past(state_r.ms_total)) || (state_r.ms_total == $past(state_r.ms_total) + 32'd1), "ms count jumped")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Breathing PWM and triangle tone tick: testbench
// Drives timer ticks and countdown loads through the request channel. It
// runs a directed table and then random phases over both modes and several
// divider settings, and checks every result against a local timer model or a typed reading.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import ibpt_pkg::*;

  localparam int STALL_LIMIT = 400;

  // one result as the block reports it
  typedef struct packed {
    logic        ir_led;
    logic [7:0]  tone_level;
    logic [31:0] ms_count;
    logic        countdown_done;
  } reading_t;

  // local copy of the timer state
  typedef struct packed {
    logic [4:0]  ramp_step;
    logic        ramp_rising;
    logic        burst_enabled;
    logic [6:0]  frame_period;
    logic        led_level;
    logic [7:0]  tone_ticks;
    logic [8:0]  tone_phase;
    logic [7:0]  tone_sample;
    logic [6:0]  ms_prescale;
    logic [31:0] ms_total;
    logic [15:0] countdown;
  } timer_t;

  typedef enum bit {ROW_REQ, ROW_CFG} row_op_e;

  typedef struct {
    row_op_e    op;
    item_t      req;
    logic [0:0] reg_idx;
    logic [7:0] reg_val;
    bit         typed;
    reading_t   want;
  } plan_row_t;

  typedef struct {
    bit         code_mode;
    logic [7:0] divider;
    int         count;
    bit         in_idle;
    bit         out_idle;
  } phase_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;

  ibpt_in_if  in_if ();
  ibpt_out_if out_if ();

  ir_breathing_pwm_and_triangle_tone_tick DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // model state, register copies and bookkeeping
  timer_t   tmr;
  bit       code_mode_q;
  logic [7:0] tone_div_q;
  reading_t pending_readings[$];
  bit       in_idle;
  bit       out_idle;
  int       error_count;
  int       req_count;
  int       load_count;
  int       code_tick_count;
  int       checked_count;
  int       quiet_cycles;

  // directed part: loads out of reset, pulse width extremes, countdown, mode switch
  plan_row_t directed_plan [21] = '{
    '{ROW_REQ, {KIND_LOAD, 6'd0,  1'b0, 16'h0000}, CFG_CODE_MODE, 8'd0, 1'b1,
      {1'b0, 8'd128, 32'd0, 1'b1}},
    '{ROW_REQ, {KIND_LOAD, 6'd63, 1'b1, 16'hFFFF}, CFG_CODE_MODE, 8'd0, 1'b1,
      {1'b0, 8'd128, 32'd0, 1'b0}},
    '{ROW_REQ, {KIND_TICK, 6'd42, 1'b0, 16'h0000}, CFG_CODE_MODE, 8'd0, 1'b0, '0},
    '{ROW_REQ, {KIND_TICK, 6'd63, 1'b1, 16'hAAAA}, CFG_CODE_MODE, 8'd0, 1'b0, '0},
    '{ROW_REQ, {KIND_TICK, 6'd0,  1'b0, 16'h5555}, CFG_CODE_MODE, 8'd0, 1'b0, '0},
    '{ROW_REQ, {KIND_TICK, 6'd0,  1'b1, 16'hFFFF}, CFG_CODE_MODE, 8'd0, 1'b0, '0},
    // a gated load keeps the led, an ungated one clears it
    '{ROW_REQ, {KIND_LOAD, 6'd21, 1'b1, 16'd3},    CFG_CODE_MODE, 8'd0, 1'b0, '0},
    '{ROW_REQ, {KIND_LOAD, 6'd21, 1'b0, 16'd2},    CFG_CODE_MODE, 8'd0, 1'b0, '0},
    // gated carrier, count down to zero and hold there
    '{ROW_CFG, '0, CFG_CODE_MODE, 8'd1, 1'b0, '0},
    '{ROW_REQ, {KIND_TICK, 6'd0,  1'b1, 16'h0000}, CFG_CODE_MODE, 8'd0, 1'b0, '0},
    '{ROW_REQ, {KIND_TICK, 6'd63, 1'b0, 16'hFFFF}, CFG_CODE_MODE, 8'd0, 1'b0, '0},
    '{ROW_REQ, {KIND_TICK, 6'd0,  1'b1, 16'h0000}, CFG_CODE_MODE, 8'd0, 1'b0, '0},
    '{ROW_REQ, {KIND_TICK, 6'd0,  1'b1, 16'h0000}, CFG_CODE_MODE, 8'd0, 1'b0, '0},
    '{ROW_REQ, {KIND_LOAD, 6'd63, 1'b1, 16'h0000}, CFG_CODE_MODE, 8'd0, 1'b0, '0},
    // divider at its top, then back to breathing with all state kept
    '{ROW_CFG, '0, CFG_TONE_DIVIDER, 8'd255, 1'b0, '0},
    '{ROW_CFG, '0, CFG_CODE_MODE, 8'd0, 1'b0, '0},
    '{ROW_REQ, {KIND_TICK, 6'd42, 1'b1, 16'hFFFF}, CFG_CODE_MODE, 8'd0, 1'b0, '0},
    '{ROW_REQ, {KIND_TICK, 6'd10, 1'b0, 16'h0001}, CFG_CODE_MODE, 8'd0, 1'b0, '0},
    '{ROW_REQ, {KIND_LOAD, 6'd1,  1'b0, 16'h0001}, CFG_CODE_MODE, 8'd0, 1'b0, '0},
    '{ROW_CFG, '0, CFG_TONE_DIVIDER, 8'd0, 1'b0, '0},
    '{ROW_REQ, {KIND_TICK, 6'd1,  1'b1, 16'h8000}, CFG_CODE_MODE, 8'd0, 1'b0, '0}
  };

  // random phases: long breathing runs so the frame counter wraps at least once
  phase_t phases [7] = '{
    '{1'b0, 8'd0,   500, 1'b0, 1'b0},
    '{1'b1, 8'd0,    30, 1'b1, 1'b1},
    '{1'b0, 8'd0,   300, 1'b1, 1'b0},
    '{1'b0, 8'd255, 250, 1'b0, 1'b1},
    '{1'b1, 8'd255,  20, 1'b1, 1'b1},
    '{1'b0, 8'd7,   350, 1'b1, 1'b1},
    '{1'b0, 8'd1,   150, 1'b0, 1'b0}
  };

  // advance the timer model by one request and return the reading it gives
  function automatic reading_t advance_timer(input item_t req);
    if (req.kind == KIND_LOAD) begin
      tmr.countdown = req.countdown_value;
      if (!req.carrier_gate) tmr.led_level = 1'b0;
    end else begin
      if (code_mode_q) begin
        if (req.carrier_gate) tmr.led_level = ~tmr.led_level;
        if (tmr.countdown != 16'd0) tmr.countdown = tmr.countdown - 16'd1;
      end else begin
        // up/down ramp gating the carrier
        if (tmr.ramp_rising) begin
          tmr.ramp_step = tmr.ramp_step + 5'd1;
          if (tmr.ramp_step > RAMP_TOP) tmr.ramp_rising = 1'b0;
          tmr.led_level = tmr.burst_enabled ? ~tmr.led_level : 1'b0;
        end else begin
          if (tmr.ramp_step != 5'd0) tmr.ramp_step = tmr.ramp_step - 5'd1;
          if (tmr.ramp_step == 5'd0) begin
            tmr.ramp_rising  = 1'b1;
            tmr.frame_period = tmr.frame_period + 7'd1;
          end
          tmr.led_level = 1'b0;
        end
        // burst window within the frame
        if (tmr.frame_period > {1'b0, req.pulse_width}) begin
          tmr.burst_enabled = 1'b0;
          if (tmr.frame_period > PWM_FRAME_TOP) begin
            tmr.frame_period = 7'd0;
            if (req.pulse_width != 6'd0) tmr.burst_enabled = 1'b1;
          end
        end
        // triangle tone, phase wraps at 512 through the 9-bit width
        tmr.tone_ticks = tmr.tone_ticks + 8'd1;
        if (tmr.tone_ticks > tone_div_q) begin
          tmr.tone_ticks = 8'd0;
          tmr.tone_phase = tmr.tone_phase + 9'd1;
          if (tmr.tone_phase > 9'd255)
            tmr.tone_sample = 8'(10'd512 - {1'b0, tmr.tone_phase});
          else
            tmr.tone_sample = tmr.tone_phase[7:0];
        end
      end
      // millisecond prescaler runs in both modes
      tmr.ms_prescale = tmr.ms_prescale + 7'd1;
      if (tmr.ms_prescale >= MS_PRESCALE) begin
        tmr.ms_total    = tmr.ms_total + 32'd1;
        tmr.ms_prescale = 7'd0;
      end
    end
    return {tmr.led_level, tmr.tone_sample, tmr.ms_total, tmr.countdown == 16'd0};
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // send one request, after a random gap when in_idle is set; returns at the falling edge after acceptance
  task automatic push_request(input item_t req, input bit typed, input reading_t want);
    int gap;
    reading_t predicted;
    gap = in_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    {in_if.kind, in_if.pulse_width, in_if.carrier_gate, in_if.countdown_value} <= req;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    req_count++;
    if (req.kind == KIND_LOAD) load_count++;
    else if (code_mode_q) code_tick_count++;
    predicted = advance_timer(req);
    pending_readings.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // register write once the block has drained
  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_CODE_MODE) code_mode_q = val[0];
    else tone_div_q = val;
  endtask

  // result receiver with random stalls when out_idle is set
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = out_idle ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      @(negedge clk);
    end
  end

  // compare each accepted result with the oldest pending reading
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_readings.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing pending, expected none, actual %0h", $time,
                 {out_if.ir_led, out_if.tone_level, out_if.ms_count, out_if.countdown_done});
      end else begin
        want = pending_readings.pop_front();
        checked_count++;
        check_field("ir_led", want.ir_led, out_if.ir_led);
        check_field("tone_level", want.tone_level, out_if.tone_level);
        check_field("ms_count", want.ms_count, out_if.ms_count);
        check_field("countdown_done", want.countdown_done, out_if.countdown_done);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d readings pending", $time,
               quiet_cycles, pending_readings.size());
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    item_t req;
    logic [5:0] pw_hold;
    int stretch_left;
    int load_pct;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_CODE_MODE;
    cfg_data              = 8'd0;
    in_if.valid           = 1'b0;
    in_if.kind            = KIND_TICK;
    in_if.pulse_width     = 6'd0;
    in_if.carrier_gate    = 1'b0;
    in_if.countdown_value = 16'd0;
    in_idle               = 1'b1;
    out_idle              = 1'b1;
    error_count           = 0;
    req_count             = 0;
    load_count            = 0;
    code_tick_count       = 0;
    checked_count         = 0;
    quiet_cycles          = 0;
    stretch_left          = 0;
    pw_hold               = 6'd0;
    code_mode_q           = 1'b0;
    tone_div_q            = 8'd0;
    tmr                   = '0;
    tmr.ramp_rising       = 1'b1;
    tmr.burst_enabled     = 1'b1;
    tmr.tone_sample       = TONE_RESET;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (directed_plan[r]) begin
      if (directed_plan[r].op == ROW_CFG)
        write_reg(directed_plan[r].reg_idx, directed_plan[r].reg_val);
      else
        push_request(directed_plan[r].req, directed_plan[r].typed, directed_plan[r].want);
    end

    // random phases, each starting from a drained block
    foreach (phases[p]) begin
      write_reg(CFG_CODE_MODE, {7'd0, phases[p].code_mode});
      write_reg(CFG_TONE_DIVIDER, phases[p].divider);
      in_idle  = phases[p].in_idle;
      out_idle = phases[p].out_idle;
      load_pct = phases[p].code_mode ? 15 : 4;
      repeat (phases[p].count) begin
        // pulse width held over stretches: zero, inside the frame, or beyond it
        if (stretch_left == 0) begin
          case ($urandom_range(0, 3))
            0: pw_hold = 6'd0;
            1: pw_hold = 6'($urandom_range(43, 63));
            default: pw_hold = 6'($urandom_range(1, 42));
          endcase
          stretch_left = $urandom_range(20, 200);
        end
        stretch_left--;
        req.kind            = ($urandom_range(0, 99) < load_pct) ? KIND_LOAD : KIND_TICK;
        req.pulse_width     = ($urandom_range(0, 19) == 0) ? 6'($urandom) : pw_hold;
        req.carrier_gate    = 1'($urandom);
        req.countdown_value = $urandom_range(0, 1) ? 16'($urandom_range(0, 24))
                                                   : 16'($urandom);
        push_request(req, 1'b0, '0);
      end
    end

    in_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("tb_top: %0d requests sent, %0d countdown loads, %0d gated-carrier ticks",
             req_count, load_count, code_tick_count);
    $display("tb_top: %0d results compared over %0d phases, divider 0 to 255",
             checked_count, $size(phases));
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
